FILE: rtl/core/va_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// va_pkg
// Shared opcodes, payload structs and the saturation helper for the
// three-component vector unit.
// ----------------------------------------------------------------------------
package va_pkg;

   localparam int unsigned WORD_W = 32;
   localparam int unsigned ROOT_W = 32;
   localparam int unsigned LANES  = 3;

   localparam logic [3:0] OP_NEG   = 4'd0;
   localparam logic [3:0] OP_ADD   = 4'd1;
   localparam logic [3:0] OP_SUB   = 4'd2;
   localparam logic [3:0] OP_MUL   = 4'd3;
   localparam logic [3:0] OP_DIV   = 4'd4;
   localparam logic [3:0] OP_ADDS  = 4'd5;
   localparam logic [3:0] OP_SUBS  = 4'd6;
   localparam logic [3:0] OP_MULS  = 4'd7;
   localparam logic [3:0] OP_DIVS  = 4'd8;
   localparam logic [3:0] OP_LEN   = 4'd9;
   localparam logic [3:0] OP_NORM  = 4'd10;
   localparam logic [3:0] OP_DIR   = 4'd11;
   localparam logic [3:0] OP_DIST  = 4'd12;
   localparam logic [3:0] OP_DOT   = 4'd13;
   localparam logic [3:0] OP_CROSS = 4'd14;

   localparam logic signed [67:0] WIDE_MAX = 68'sd2147483647;
   localparam logic signed [67:0] WIDE_MIN = -68'sd2147483648;

   // per-lane results leaving the product stage
   typedef struct packed {
      logic signed [31:0] num;
      logic signed [31:0] den;
      logic signed [31:0] simple;
      logic               sat;
      logic signed [63:0] p;
      logic signed [63:0] q;
   } lane_type;

   // item context carried alongside the root and divider pipelines
   typedef struct packed {
      logic [3:0]       op;
      logic             sat;
      logic             err;
      logic [2:0][31:0] r;
      logic [31:0]      sc;
      logic [2:0][31:0] num;
      logic [2:0][31:0] den;
   } side_type;

   // {clipped flag, 32-bit value}
   function automatic logic [32:0] clip_word(input logic signed [67:0] v);
      logic [32:0] res;
      if (v > WIDE_MAX) begin
         res = {1'b1, 32'h7fff_ffff};
      end else if (v < WIDE_MIN) begin
         res = {1'b1, 32'h8000_0000};
      end else begin
         res = {1'b0, v[31:0]};
      end
      return res;
   endfunction

endpackage
`default_nettype wire

FILE: rtl/core/vec3_arith_unit.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// vec3_arith_unit
// Signed fixed-point three-component vector unit: lanes, merge, root and
// divider pipelines, output register.
// ----------------------------------------------------------------------------
// pipeline: 3 lane/merge stages, 32 root stages, (32 + FRAC_BITS) divider stages
//   and the output register
// throughput: one item per cycle; every opcode flows through the same pipeline
// a result left waiting stalls the whole pipeline in place
// reset: synchronous, clears only the stage valid bits and the output valid
module vec3_arith_unit #(
   parameter int FRAC_BITS = 16
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_valid,
   output logic                    req_ready,
   input  wire logic [3:0]         req_type,
   input  wire logic signed [31:0] req_ax,
   input  wire logic signed [31:0] req_ay,
   input  wire logic signed [31:0] req_az,
   input  wire logic signed [31:0] req_bx,
   input  wire logic signed [31:0] req_by_comp,
   input  wire logic signed [31:0] req_bz,
   input  wire logic signed [31:0] req_scalar_in,
   output logic                    rsp_valid,
   input  wire logic               rsp_ready,
   output logic signed [31:0]      rsp_rx,
   output logic signed [31:0]      rsp_ry,
   output logic signed [31:0]      rsp_rz,
   output logic signed [31:0]      rsp_scalar_out,
   output logic                    rsp_math_error,
   output logic                    rsp_saturated
);
   import va_pkg::*;

   localparam int QW    = WORD_W + FRAC_BITS;
   localparam int DEPTH = 3 + ROOT_W + QW;

   logic             en;
   logic [DEPTH-1:0] pipe_v_ff;
   logic [DEPTH-1:0] pipe_v_in;
   logic             out_v_ff;
   logic [3:0]       op1_ff, op2_ff;

   lane_type [2:0]   lanes;
   side_type         side_m;
   logic [63:0]      rad;
   logic [31:0]      root;
   side_type         side_sq_ff [ROOT_W];
   side_type         side_dv_ff [QW];
   side_type         side_r;
   side_type         side_d;
   logic [32:0]      len_clip;
   logic [31:0]      dv_mag  [LANES];
   logic             dv_neg  [LANES];
   logic [QW-1:0]    quo     [LANES];
   logic             quo_neg [LANES];
   logic [32:0]      q_clip  [LANES];
   logic signed [67:0] q_val [LANES];

   logic [2:0][31:0] r_in;
   logic             sat_in;
   logic signed [31:0] rx_ff, ry_ff, rz_ff, sc_ff;
   logic             err_ff, sat_ff;

   assign en        = !out_v_ff || rsp_ready;
   assign req_ready = en;
   assign pipe_v_in = {pipe_v_ff[DEPTH-2:0], req_valid && en};

   always_ff @(posedge clock) begin
      if (reset) begin
         pipe_v_ff <= '0;
         out_v_ff  <= 1'b0;
      end else if (en) begin
         pipe_v_ff <= pipe_v_in;
         out_v_ff  <= pipe_v_ff[DEPTH-1];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         op1_ff <= req_type;
         op2_ff <= op1_ff;
      end
   end

   va_lane u_lane_x (
      .clock(clock), .en(en), .op(req_type),
      .a(req_ax), .b(req_bx), .s(req_scalar_in),
      .xp1(req_ay), .xp2(req_bz), .xq1(req_az), .xq2(req_by_comp),
      .lane_out(lanes[0])
   );

   va_lane u_lane_y (
      .clock(clock), .en(en), .op(req_type),
      .a(req_ay), .b(req_by_comp), .s(req_scalar_in),
      .xp1(req_az), .xp2(req_bx), .xq1(req_ax), .xq2(req_bz),
      .lane_out(lanes[1])
   );

   va_lane u_lane_z (
      .clock(clock), .en(en), .op(req_type),
      .a(req_az), .b(req_bz), .s(req_scalar_in),
      .xp1(req_ax), .xp2(req_by_comp), .xq1(req_ay), .xq2(req_bx),
      .lane_out(lanes[2])
   );

   va_merge #(.FRAC_BITS(FRAC_BITS)) u_merge (
      .clock(clock), .en(en), .op(op2_ff), .lanes(lanes),
      .side_out(side_m), .rad_out(rad)
   );

   va_sqrt u_sqrt (.clock(clock), .en(en), .rad(rad), .root(root));

   always_ff @(posedge clock) begin
      if (en) begin
         side_sq_ff[0] <= side_m;
         for (int k = 1; k < ROOT_W; k++) begin
            side_sq_ff[k] <= side_sq_ff[k-1];
         end
      end
   end

   // length results and divisor selection once the root is known
   assign side_r   = side_sq_ff[ROOT_W-1];
   assign len_clip = clip_word(68'($signed({1'b0, root})));

   always_comb begin
      side_d = side_r;
      case (side_r.op) inside
         OP_LEN, OP_DIST: begin
            side_d.sc  = len_clip[31:0];
            side_d.sat = side_r.sat | len_clip[32];
         end
         OP_NORM, OP_DIR: begin
            side_d.err = (root == '0);
         end
         default: begin
            side_d.sc = side_r.sc;
         end
      endcase
      for (int i = 0; i < LANES; i++) begin
         if (side_r.op == OP_NORM || side_r.op == OP_DIR) begin
            dv_mag[i] = root;
            dv_neg[i] = 1'b0;
         end else begin
            dv_mag[i] = side_r.den[i][31] ? 32'(-side_r.den[i]) : side_r.den[i];
            dv_neg[i] = side_r.den[i][31];
         end
      end
   end

   for (genvar i = 0; i < LANES; i++) begin : g_div
      va_div #(.FRAC_BITS(FRAC_BITS)) u_div (
         .clock(clock), .en(en),
         .num($signed(side_r.num[i])), .den_mag(dv_mag[i]), .den_neg(dv_neg[i]),
         .quo(quo[i]), .neg(quo_neg[i])
      );
   end

   always_ff @(posedge clock) begin
      if (en) begin
         side_dv_ff[0] <= side_d;
         for (int k = 1; k < QW; k++) begin
            side_dv_ff[k] <= side_dv_ff[k-1];
         end
      end
   end

   always_comb begin
      r_in   = side_dv_ff[QW-1].r;
      sat_in = side_dv_ff[QW-1].sat;
      for (int i = 0; i < LANES; i++) begin
         q_val[i]  = quo_neg[i] ? -$signed(68'(quo[i])) : $signed(68'(quo[i]));
         q_clip[i] = clip_word(q_val[i]);
      end
      case (side_dv_ff[QW-1].op) inside
         OP_DIV, OP_DIVS, OP_NORM, OP_DIR: begin
            if (!side_dv_ff[QW-1].err) begin
               for (int i = 0; i < LANES; i++) begin
                  r_in[i] = q_clip[i][31:0];
               end
               sat_in = side_dv_ff[QW-1].sat | q_clip[0][32] | q_clip[1][32]
                        | q_clip[2][32];
            end
         end
         default: begin
            sat_in = side_dv_ff[QW-1].sat;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (en) begin
         rx_ff  <= $signed(r_in[0]);
         ry_ff  <= $signed(r_in[1]);
         rz_ff  <= $signed(r_in[2]);
         sc_ff  <= $signed(side_dv_ff[QW-1].sc);
         err_ff <= side_dv_ff[QW-1].err;
         sat_ff <= sat_in;
      end
   end

   assign rsp_valid      = out_v_ff;
   assign rsp_rx         = rx_ff;
   assign rsp_ry         = ry_ff;
   assign rsp_rz         = rz_ff;
   assign rsp_scalar_out = sc_ff;
   assign rsp_math_error = err_ff;
   assign rsp_saturated  = sat_ff;

endmodule
`default_nettype wire

FILE: rtl/core/va_lane.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// va_lane
// One component lane: add/subtract/negate with clipping, operand selection
// and the two registered 32x32 products.
// ----------------------------------------------------------------------------
module va_lane (
   input  wire logic               clock,
   input  wire logic               en,
   input  wire logic [3:0]         op,
   input  wire logic signed [31:0] a,
   input  wire logic signed [31:0] b,
   input  wire logic signed [31:0] s,
   input  wire logic signed [31:0] xp1,
   input  wire logic signed [31:0] xp2,
   input  wire logic signed [31:0] xq1,
   input  wire logic signed [31:0] xq2,
   output va_pkg::lane_type        lane_out
);
   import va_pkg::*;

   logic signed [32:0] diff;
   logic [32:0]        d_clip;
   logic signed [31:0] d;
   logic signed [32:0] sum;
   logic [32:0]        sum_clip;

   logic signed [31:0] m1_in, m2_in, n1_in, n2_in;
   logic signed [31:0] m1_ff, m2_ff, n1_ff, n2_ff;
   logic signed [31:0] num_in, den_in, simple_in;
   logic               sat_in;
   logic signed [31:0] num_ff, den_ff, simple_ff;
   logic               sat_ff;
   logic signed [63:0] p_in, q_in;
   lane_type           lane_ff;

   assign diff   = 33'(b) - 33'(a);
   assign d_clip = clip_word(68'(diff));
   assign d      = $signed(d_clip[31:0]);

   always_comb begin
      case (op)
         OP_NEG:  sum = -33'(a);
         OP_ADD:  sum = 33'(a) + 33'(b);
         OP_SUB:  sum = 33'(a) - 33'(b);
         OP_ADDS: sum = 33'(a) + 33'(s);
         OP_SUBS: sum = 33'(a) - 33'(s);
         default: sum = '0;
      endcase
   end

   assign sum_clip = clip_word(68'(sum));

   always_comb begin
      m1_in     = '0;
      m2_in     = '0;
      n1_in     = '0;
      n2_in     = '0;
      num_in    = a;
      den_in    = b;
      simple_in = $signed(sum_clip[31:0]);
      sat_in    = 1'b0;
      case (op) inside
         OP_NEG, OP_ADD, OP_SUB, OP_ADDS, OP_SUBS: begin
            sat_in = sum_clip[32];
         end
         OP_MUL, OP_DOT: begin
            m1_in = a;
            m2_in = b;
         end
         OP_MULS: begin
            m1_in = a;
            m2_in = s;
         end
         OP_DIVS: begin
            den_in = s;
         end
         OP_CROSS: begin
            m1_in = xp1;
            m2_in = xp2;
            n1_in = xq1;
            n2_in = xq2;
         end
         OP_LEN, OP_NORM: begin
            m1_in = a;
            m2_in = a;
         end
         OP_DIR, OP_DIST: begin
            m1_in  = d;
            m2_in  = d;
            num_in = d;
            sat_in = d_clip[32];
         end
         default: begin
            m1_in = '0;
         end
      endcase
   end

   assign p_in = m1_ff * m2_ff;
   assign q_in = n1_ff * n2_ff;

   always_ff @(posedge clock) begin
      if (en) begin
         m1_ff          <= m1_in;
         m2_ff          <= m2_in;
         n1_ff          <= n1_in;
         n2_ff          <= n2_in;
         num_ff         <= num_in;
         den_ff         <= den_in;
         simple_ff      <= simple_in;
         sat_ff         <= sat_in;
         lane_ff.p      <= p_in;
         lane_ff.q      <= q_in;
         lane_ff.num    <= num_ff;
         lane_ff.den    <= den_ff;
         lane_ff.simple <= simple_ff;
         lane_ff.sat    <= sat_ff;
      end
   end

   assign lane_out = lane_ff;

endmodule
`default_nettype wire

FILE: rtl/core/va_merge.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// va_merge
// Combines the three lanes: product scaling, cross and dot sums, the sum of
// squares for the root unit and the divide-by-zero check.
// ----------------------------------------------------------------------------
module va_merge #(
   parameter int FRAC_BITS = 16
) (
   input  wire logic                   clock,
   input  wire logic                   en,
   input  wire logic [3:0]             op,
   input  va_pkg::lane_type [2:0]      lanes,
   output va_pkg::side_type            side_out,
   output logic [63:0]                 rad_out
);
   import va_pkg::*;

   side_type           side_in;
   side_type           side_ff;
   logic [63:0]        rad_in;
   logic [63:0]        rad_ff;
   logic signed [65:0] dot_sum;
   logic [32:0]        dot_clip;
   logic [2:0][32:0]   mul_clip;
   logic [2:0][32:0]   crs_clip;
   logic signed [64:0] crs_diff [LANES];
   logic               den_zero;

   always_comb begin
      for (int i = 0; i < LANES; i++) begin
         crs_diff[i] = 65'(lanes[i].p) - 65'(lanes[i].q);
         mul_clip[i] = clip_word(68'(lanes[i].p >>> FRAC_BITS));
         crs_clip[i] = clip_word(68'(crs_diff[i] >>> FRAC_BITS));
      end
   end

   assign dot_sum  = 66'(lanes[0].p) + 66'(lanes[1].p) + 66'(lanes[2].p);
   assign dot_clip = clip_word(68'(dot_sum >>> FRAC_BITS));
   // squares are non-negative and their sum stays below 2^64
   assign rad_in   = $unsigned(lanes[0].p) + $unsigned(lanes[1].p) + $unsigned(lanes[2].p);
   assign den_zero = (lanes[0].den == '0) || (lanes[1].den == '0) || (lanes[2].den == '0);

   always_comb begin
      side_in     = '0;
      side_in.op  = op;
      for (int i = 0; i < LANES; i++) begin
         side_in.num[i] = lanes[i].num;
         side_in.den[i] = lanes[i].den;
      end
      case (op) inside
         OP_NEG, OP_ADD, OP_SUB, OP_ADDS, OP_SUBS: begin
            for (int i = 0; i < LANES; i++) begin
               side_in.r[i] = lanes[i].simple;
            end
            side_in.sat = lanes[0].sat | lanes[1].sat | lanes[2].sat;
         end
         OP_MUL, OP_MULS: begin
            for (int i = 0; i < LANES; i++) begin
               side_in.r[i] = mul_clip[i][31:0];
            end
            side_in.sat = mul_clip[0][32] | mul_clip[1][32] | mul_clip[2][32];
         end
         OP_CROSS: begin
            for (int i = 0; i < LANES; i++) begin
               side_in.r[i] = crs_clip[i][31:0];
            end
            side_in.sat = crs_clip[0][32] | crs_clip[1][32] | crs_clip[2][32];
         end
         OP_DOT: begin
            side_in.sc  = dot_clip[31:0];
            side_in.sat = dot_clip[32];
         end
         OP_DIV, OP_DIVS: begin
            side_in.err = den_zero;
         end
         OP_DIR, OP_DIST: begin
            side_in.sat = lanes[0].sat | lanes[1].sat | lanes[2].sat;
         end
         default: begin
            side_in.sat = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (en) begin
         side_ff <= side_in;
         rad_ff  <= rad_in;
      end
   end

   assign side_out = side_ff;
   assign rad_out  = rad_ff;

endmodule
`default_nettype wire

FILE: rtl/core/va_sqrt.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// va_sqrt
// Pipelined integer square root of a 64-bit radicand, one root bit per stage.
// ----------------------------------------------------------------------------
module va_sqrt (
   input  wire logic        clock,
   input  wire logic        en,
   input  wire logic [63:0] rad,
   output logic [31:0]      root
);
   import va_pkg::*;

   logic [33:0] rem_ff  [ROOT_W];
   logic [31:0] root_ff [ROOT_W];
   logic [63:0] rest_ff [ROOT_W];

   for (genvar k = 0; k < ROOT_W; k++) begin : g_stage
      logic [33:0] rem_p;
      logic [31:0] root_p;
      logic [63:0] rest_p;
      logic [35:0] sh;
      logic [35:0] trial;
      logic        ge;
      logic [33:0] rem_in;

      if (k == 0) begin : g_first
         assign rem_p  = '0;
         assign root_p = '0;
         assign rest_p = rad;
      end else begin : g_next
         assign rem_p  = rem_ff[k-1];
         assign root_p = root_ff[k-1];
         assign rest_p = rest_ff[k-1];
      end

      assign sh     = {rem_p, rest_p[63:62]};
      assign trial  = {2'b00, root_p, 2'b01};
      assign ge     = (sh >= trial);
      assign rem_in = ge ? 34'(sh - trial) : sh[33:0];

      always_ff @(posedge clock) begin
         if (en) begin
            rem_ff[k]  <= rem_in;
            root_ff[k] <= {root_p[30:0], ge};
            rest_ff[k] <= {rest_p[61:0], 2'b00};
         end
      end
   end

   assign root = root_ff[ROOT_W-1];

endmodule
`default_nettype wire

FILE: rtl/core/va_div.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// va_div
// Pipelined restoring divider: |num| * 2^FRAC_BITS / den, one quotient bit
// per stage, sign carried alongside.
// ----------------------------------------------------------------------------
module va_div #(
   parameter int FRAC_BITS = 16
) (
   input  wire logic                             clock,
   input  wire logic                             en,
   input  wire logic signed [31:0]               num,
   input  wire logic [31:0]                      den_mag,
   input  wire logic                             den_neg,
   output logic [va_pkg::WORD_W+FRAC_BITS-1:0]   quo,
   output logic                                  neg
);
   import va_pkg::*;

   localparam int QW = WORD_W + FRAC_BITS;

   logic [31:0]   num_mag;
   logic [31:0]   rem_ff  [QW];
   logic [QW-1:0] rest_ff [QW];
   logic [QW-1:0] quo_ff  [QW];
   logic [31:0]   den_ff  [QW];
   logic          neg_ff  [QW];

   assign num_mag = num[31] ? 32'(-num) : 32'(num);

   for (genvar k = 0; k < QW; k++) begin : g_stage
      logic [31:0]   rem_p;
      logic [QW-1:0] rest_p;
      logic [QW-1:0] quo_p;
      logic [31:0]   den_p;
      logic          neg_p;
      logic [32:0]   sh;
      logic          ge;
      logic [31:0]   rem_in;

      if (k == 0) begin : g_first
         assign rem_p  = '0;
         assign rest_p = {num_mag, {FRAC_BITS{1'b0}}};
         assign quo_p  = '0;
         assign den_p  = den_mag;
         assign neg_p  = num[31] ^ den_neg;
      end else begin : g_next
         assign rem_p  = rem_ff[k-1];
         assign rest_p = rest_ff[k-1];
         assign quo_p  = quo_ff[k-1];
         assign den_p  = den_ff[k-1];
         assign neg_p  = neg_ff[k-1];
      end

      assign sh     = {rem_p, rest_p[QW-1]};
      assign ge     = (sh >= {1'b0, den_p});
      assign rem_in = ge ? 32'(sh - {1'b0, den_p}) : sh[31:0];

      always_ff @(posedge clock) begin
         if (en) begin
            rem_ff[k]  <= rem_in;
            rest_ff[k] <= {rest_p[QW-2:0], 1'b0};
            quo_ff[k]  <= {quo_p[QW-2:0], ge};
            den_ff[k]  <= den_p;
            neg_ff[k]  <= neg_p;
         end
      end
   end

   assign quo = quo_ff[QW-1];
   assign neg = neg_ff[QW-1];

endmodule
`default_nettype wire

FILE: rtl/core/va_checker.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// va_checker
// Port-level checks for the vector unit, bound to the top level.
// ----------------------------------------------------------------------------
module va_checker (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        req_valid,
   input wire logic        req_ready,
   input wire logic        rsp_valid,
   input wire logic        rsp_ready,
   input wire logic [31:0] rsp_rx,
   input wire logic [31:0] rsp_ry,
   input wire logic [31:0] rsp_rz,
   input wire logic [31:0] rsp_scalar_out,
   input wire logic        rsp_math_error
);

   // no result right after reset
   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result valid after reset");

   // input side only closes while a result is held back
   a_ready_stall: assert property (@(posedge clock) disable iff (reset)
      !req_ready |-> (rsp_valid && !rsp_ready))
      else $error("input blocked without output stall");

   // a held result does not change
   a_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(rsp_rx) && $stable(rsp_ry)
      && $stable(rsp_rz) && $stable(rsp_scalar_out)))
      else $error("held result changed");

   // math errors give a zero vector
   a_err_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_math_error) |-> (rsp_rx == '0 && rsp_ry == '0 && rsp_rz == '0))
      else $error("nonzero vector with math error");

   // vector and scalar results never both carry data
   a_exclusive: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_rx != '0 || rsp_ry != '0 || rsp_rz != '0))
      |-> (rsp_scalar_out == '0))
      else $error("vector and scalar result both nonzero");

endmodule

bind vec3_arith_unit va_checker u_va_checker (
   .clock(clock), .reset(reset),
   .req_valid(req_valid), .req_ready(req_ready),
   .rsp_valid(rsp_valid), .rsp_ready(rsp_ready),
   .rsp_rx(rsp_rx), .rsp_ry(rsp_ry), .rsp_rz(rsp_rz),
   .rsp_scalar_out(rsp_scalar_out), .rsp_math_error(rsp_math_error)
);
`default_nettype wire

FILE: tb/sv/tb_vec3_arith_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_vec3_arith_unit
// Drives opcode/vector/scalar items through the vector unit with random
// idling on both sides and a long output stall. Each item is checked field by
// field against a fixed-point prediction of the same arithmetic.
// ----------------------------------------------------------------------------
module tb_vec3_arith_unit;
   import va_pkg::*;

   localparam int         FRAC      = 16;
   localparam logic [3:0] OP_UNUSED = 4'd15;
   localparam int         N_RANDOM  = 1030;

   typedef logic signed [67:0] wide_type;

   typedef struct {
      logic signed [31:0] rx, ry, rz, sc;
      logic               err, sat;
   } vec_result_type;

   class vec_scoreboard;
      vec_result_type pending_results[$];
      int             errors = 0;

      function automatic logic signed [31:0] clip(input wide_type v, inout bit s);
         if (v > 68'sd2147483647) begin
            s = 1;
            return 32'sh7fff_ffff;
         end
         if (v < -68'sd2147483648) begin
            s = 1;
            return 32'sh8000_0000;
         end
         return v[31:0];
      endfunction

      function automatic wide_type isqrt(input logic [67:0] n);
         logic [67:0] res, b;
         res = 0;
         b   = 68'd1 << 66;
         while (b > n) b = b >> 2;
         while (b != 0) begin
            if (n >= res + b) begin
               n   = n - (res + b);
               res = (res >> 1) + b;
            end else begin
               res = res >> 1;
            end
            b = b >> 2;
         end
         return wide_type'(res);
      endfunction

      function automatic wide_type fdiv(input wide_type n, input wide_type d);
         return (n <<< FRAC) / d;
      endfunction

      function automatic void normalize(input wide_type v[3], output wide_type r[3],
                                        inout bit err, inout bit s);
         wide_type len;
         len = isqrt(v[0] * v[0] + v[1] * v[1] + v[2] * v[2]);
         for (int i = 0; i < 3; i++) r[i] = 0;
         if (len == 0) begin
            err = 1;
         end else begin
            for (int i = 0; i < 3; i++) r[i] = clip(fdiv(v[i], len), s);
         end
      endfunction

      function automatic vec_result_type predict_result(input logic [3:0] op,
            input logic signed [31:0] ax, ay, az, bx, by, bz, sv);
         wide_type       a[3], b[3], r[3], d[3], s, sc;
         bit             err, sat;
         vec_result_type e;
         a[0] = ax; a[1] = ay; a[2] = az;
         b[0] = bx; b[1] = by; b[2] = bz;
         s = sv; sc = 0; err = 0; sat = 0;
         for (int i = 0; i < 3; i++) r[i] = 0;
         case (op)
            OP_NEG:   for (int i = 0; i < 3; i++) r[i] = clip(-a[i], sat);
            OP_ADD:   for (int i = 0; i < 3; i++) r[i] = clip(a[i] + b[i], sat);
            OP_SUB:   for (int i = 0; i < 3; i++) r[i] = clip(a[i] - b[i], sat);
            OP_MUL:   for (int i = 0; i < 3; i++) r[i] = clip((a[i] * b[i]) >>> FRAC, sat);
            OP_DIV: begin
               if (b[0] == 0 || b[1] == 0 || b[2] == 0) err = 1;
               else for (int i = 0; i < 3; i++) r[i] = clip(fdiv(a[i], b[i]), sat);
            end
            OP_ADDS:  for (int i = 0; i < 3; i++) r[i] = clip(a[i] + s, sat);
            OP_SUBS:  for (int i = 0; i < 3; i++) r[i] = clip(a[i] - s, sat);
            OP_MULS:  for (int i = 0; i < 3; i++) r[i] = clip((a[i] * s) >>> FRAC, sat);
            OP_DIVS: begin
               if (s == 0) err = 1;
               else for (int i = 0; i < 3; i++) r[i] = clip(fdiv(a[i], s), sat);
            end
            OP_LEN:   sc = clip(isqrt(a[0] * a[0] + a[1] * a[1] + a[2] * a[2]), sat);
            OP_NORM:  normalize(a, r, err, sat);
            OP_DIR: begin
               for (int i = 0; i < 3; i++) d[i] = clip(b[i] - a[i], sat);
               normalize(d, r, err, sat);
            end
            OP_DIST: begin
               for (int i = 0; i < 3; i++) d[i] = clip(b[i] - a[i], sat);
               sc = clip(isqrt(d[0] * d[0] + d[1] * d[1] + d[2] * d[2]), sat);
            end
            OP_DOT:   sc = clip((a[0] * b[0] + a[1] * b[1] + a[2] * b[2]) >>> FRAC, sat);
            OP_CROSS: begin
               r[0] = clip((a[1] * b[2] - a[2] * b[1]) >>> FRAC, sat);
               r[1] = clip((a[2] * b[0] - a[0] * b[2]) >>> FRAC, sat);
               r[2] = clip((a[0] * b[1] - a[1] * b[0]) >>> FRAC, sat);
            end
            default: ;
         endcase
         // a zero divisor clears everything, flags included
         if (err && (op == OP_DIV || op == OP_DIVS)) sat = 0;
         e.rx = r[0][31:0]; e.ry = r[1][31:0]; e.rz = r[2][31:0];
         e.sc = sc[31:0]; e.err = err; e.sat = sat;
         return e;
      endfunction

      function void note_request(input logic [3:0] op,
            input logic signed [31:0] ax, ay, az, bx, by, bz, sv);
         pending_results.push_back(predict_result(op, ax, ay, az, bx, by, bz, sv));
      endfunction

      task report(input string what, input logic signed [31:0] got, exp_v);
         $display("%0t mismatch on %s: got %h expected %h", $time, what, got, exp_v);
         errors++;
      endtask

      task check_result(input vec_result_type got);
         vec_result_type e;
         if (pending_results.size() == 0) begin
            report("unexpected item", 0, 0);
            return;
         end
         e = pending_results.pop_front();
         if (got.rx !== e.rx) report("rx", got.rx, e.rx);
         if (got.ry !== e.ry) report("ry", got.ry, e.ry);
         if (got.rz !== e.rz) report("rz", got.rz, e.rz);
         if (got.sc !== e.sc) report("scalar_out", got.sc, e.sc);
         if (got.err !== e.err) report("math_error", got.err, e.err);
         if (got.sat !== e.sat) report("saturated", got.sat, e.sat);
      endtask
   endclass

   logic                clock = 0;
   logic                reset = 1;
   logic                req_valid = 0, req_ready;
   logic [3:0]          req_type = OP_NEG;
   logic signed [31:0]  req_ax = 0, req_ay = 0, req_az = 0;
   logic signed [31:0]  req_bx = 0, req_by_comp = 0, req_bz = 0, req_scalar_in = 0;
   logic                rsp_valid, rsp_ready = 0;
   logic signed [31:0]  rsp_rx, rsp_ry, rsp_rz, rsp_scalar_out;
   logic                rsp_math_error, rsp_saturated;

   vec_scoreboard sb = new();
   int            accepted_items = 0;
   bit            no_idle = 0;

   vec3_arith_unit #(.FRAC_BITS(FRAC)) dut (
      .clock, .reset, .req_valid, .req_ready, .req_type, .req_ax, .req_ay,
      .req_az, .req_bx, .req_by_comp, .req_bz, .req_scalar_in, .rsp_valid,
      .rsp_ready, .rsp_rx, .rsp_ry, .rsp_rz, .rsp_scalar_out, .rsp_math_error,
      .rsp_saturated
   );

   always begin
      #5 clock = 1;
      #5 clock = 0;
   end

   always @(posedge clock) begin
      if (!reset && req_valid && req_ready) begin
         sb.note_request(req_type, req_ax, req_ay, req_az, req_bx, req_by_comp,
                         req_bz, req_scalar_in);
         accepted_items++;
      end
      if (!reset && rsp_valid && rsp_ready) begin
         sb.check_result('{rx: rsp_rx, ry: rsp_ry, rz: rsp_rz, sc: rsp_scalar_out,
                           err: rsp_math_error, sat: rsp_saturated});
      end
   end

   task send_vec(input logic [3:0] op, input logic signed [31:0] ax, ay, az,
                 bx, by, bz, sv);
      int gap;
      req_type <= op; req_ax <= ax; req_ay <= ay; req_az <= az;
      req_bx <= bx; req_by_comp <= by; req_bz <= bz; req_scalar_in <= sv;
      req_valid <= 1;
      do @(posedge clock); while (!req_ready);
      gap = no_idle ? 0 : $urandom_range(0, 8);
      if (gap > 0) begin
         req_valid <= 0;
         repeat (gap) @(posedge clock);
      end
   endtask

   function automatic logic signed [31:0] rand_word();
      case ($urandom_range(0, 6))
         0:       return $urandom;
         1:       return $signed($urandom_range(0, 32'h0020_0000)) - 32'sh0010_0000;
         2:       return $signed($urandom_range(0, 32'h0008_0000)) - 32'sh0004_0000;
         3:       return 0;
         4:       return 32'sh7fff_ffff;
         5:       return 32'sh8000_0000;
         default: return $urandom;
      endcase
   endfunction

   // output side: random stalls, one long hold once over 400 items are accepted
   initial begin
      int  gap;
      bit  held;
      held = 0;
      @(negedge reset);
      forever begin
         if (!held && accepted_items > 400) begin
            held = 1;
            rsp_ready <= 0;
            repeat (300) @(posedge clock);
         end else begin
            gap = no_idle ? 0 : $urandom_range(0, 8);
            if (gap > 0) begin
               rsp_ready <= 0;
               repeat (gap) @(posedge clock);
            end
         end
         rsp_ready <= 1;
         do @(posedge clock); while (!rsp_valid);
      end
   end

   initial begin
      #2_000_000;
      $display("Testbench completed WITH ERRORS");
      $finish;
   end

   initial begin
      logic [3:0]         op;
      logic signed [31:0] ax, ay, az, bx, by, bz, sv;
      localparam logic signed [31:0] ONE  = 32'sh0001_0000;
      localparam logic signed [31:0] PMAX = 32'sh7fff_ffff;
      localparam logic signed [31:0] NMIN = 32'sh8000_0000;
      repeat (11) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      send_vec(OP_NEG,   NMIN, PMAX, 0, 0, 0, 0, 0);
      send_vec(OP_ADD,   PMAX, NMIN, ONE, ONE, NMIN, -ONE, 0);
      send_vec(OP_SUB,   NMIN, PMAX, 5, ONE, NMIN, 7, 0);
      send_vec(OP_MUL,   PMAX, NMIN, -3, PMAX, NMIN, ONE, 0);
      send_vec(OP_MUL,   -1, 3 * ONE, -ONE, 1, -ONE / 2, ONE, 0);
      send_vec(OP_DIV,   NMIN, PMAX, ONE, -1, 1, 3 * ONE, 0);
      send_vec(OP_DIV,   ONE, ONE, ONE, ONE, 0, ONE, 0);
      send_vec(OP_ADDS,  PMAX, NMIN, 0, 0, 0, 0, PMAX);
      send_vec(OP_SUBS,  PMAX, NMIN, 0, 0, 0, 0, NMIN);
      send_vec(OP_MULS,  PMAX, NMIN, -ONE, 0, 0, 0, NMIN);
      send_vec(OP_DIVS,  NMIN, PMAX, ONE, 0, 0, 0, -1);
      send_vec(OP_DIVS,  ONE, ONE, ONE, 0, 0, 0, 0);
      send_vec(OP_LEN,   NMIN, NMIN, NMIN, 0, 0, 0, 0);
      send_vec(OP_LEN,   3 * ONE, 4 * ONE, 0, 0, 0, 0, 0);
      send_vec(OP_NORM,  0, 0, 0, 0, 0, 0, 0);
      send_vec(OP_NORM,  NMIN, PMAX, 1, 0, 0, 0, 0);
      send_vec(OP_NORM,  1, 0, 0, 0, 0, 0, 0);
      send_vec(OP_DIR,   ONE, 2, -ONE, ONE, 2, -ONE, 0);
      send_vec(OP_DIR,   NMIN, PMAX, 0, PMAX, NMIN, ONE, 0);
      send_vec(OP_DIST,  NMIN, PMAX, NMIN, PMAX, NMIN, PMAX, 0);
      send_vec(OP_DOT,   PMAX, PMAX, PMAX, PMAX, PMAX, PMAX, 0);
      send_vec(OP_DOT,   NMIN, NMIN, NMIN, PMAX, PMAX, PMAX, 0);
      send_vec(OP_CROSS, NMIN, PMAX, NMIN, PMAX, NMIN, PMAX, 0);
      send_vec(OP_UNUSED, ONE, ONE, ONE, ONE, ONE, ONE, ONE);

      for (int n = 0; n < N_RANDOM; n++) begin
         // stretches with no idling on either side
         if (n % 200 == 100) no_idle = 1;
         if (n % 200 == 160) no_idle = 0;
         op = 4'($urandom_range(0, 15));
         ax = rand_word(); ay = rand_word(); az = rand_word();
         bx = rand_word(); by = rand_word(); bz = rand_word();
         sv = rand_word();
         if ($urandom_range(0, 9) == 0) begin
            bx = ax; by = ay; bz = az;
         end
         send_vec(op, ax, ay, az, bx, by, bz, sv);
      end
      req_valid <= 0;
      no_idle = 0;

      while (sb.pending_results.size() != 0) @(posedge clock);
      repeat (100) @(posedge clock);
      if (sb.errors == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

endmodule

FILE: files.f
rtl/core/va_pkg.sv
rtl/core/va_lane.sv
rtl/core/va_merge.sv
rtl/core/va_sqrt.sv
rtl/core/va_div.sv
rtl/core/vec3_arith_unit.sv
rtl/core/va_checker.sv
tb/sv/tb_vec3_arith_unit.sv
